@@ hw/rtl/krm_pkg.sv @@
// Shared types and constants for the keystroke rate meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package krm_pkg;

  localparam int unsigned RATE_W             = 16;
  localparam int unsigned AGE_W              = 8;
  localparam int unsigned WINDOW_BUCKETS_DEF = 8;
  localparam int unsigned HISTORY_DEPTH_DEF  = 64;

  typedef enum logic [1:0] {
    OP_KEYSTROKE = 2'd0,
    OP_REFRESH   = 2'd1,
    OP_HISTORY   = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [AGE_W-1:0] history_age;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] current_rate;
    logic [RATE_W-1:0] peak_rate;
    logic [RATE_W-1:0] history_value;
  } out_t;

endpackage

@@ hw/rtl/krm_ring.sv @@
// Ring storage for the rate meter: one write and one registered read port,
// per-entry valid bits so unwritten entries read as zero. Uses krm_pkg.
`timescale 1ns / 1ps

module krm_ring #(
  parameter int unsigned DEPTH = krm_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [krm_pkg::RATE_W-1:0] wr_data,
  output logic [krm_pkg::RATE_W-1:0] rd_data
);
  import krm_pkg::*;

  logic [RATE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [RATE_W-1:0] mem_q_r;
  logic              rd_ok_r;
  logic              byp_r;
  logic [RATE_W-1:0] byp_data_r;
  logic              hit;

  // a write landing on the address being read in the same edge wins
  assign hit = rd_en && wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= valid_r[rd_addr];
        byp_r   <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r   ? byp_data_r :
                   rd_ok_r ? mem_q_r    : '0;

endmodule

@@ hw/rtl/keystroke_rate_meter.sv @@
// Top level of the keystroke rate meter: pointer logic, execute stage and
// result register. Uses krm_pkg and two krm_ring instances.
`timescale 1ns / 1ps

// One result word per input word, one word per cycle sustained; the execute
// stage and result register lie between acceptance and out_valid. Ring reads
// issue on acceptance, and the window or history pointer moves for a refresh
// or history word; the execute stage then updates the bucket, the running
// window sum and the peak, and writes the rings, forwarding a write to a read
// of the same entry. Unwritten ring entries read as zero from reset, with no
// clearing pass. out_ready low stalls the pipe once both stages are full.
module keystroke_rate_meter #(
  parameter int unsigned WINDOW_BUCKETS = krm_pkg::WINDOW_BUCKETS_DEF,
  parameter int unsigned HISTORY_DEPTH  = krm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  krm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output krm_pkg::out_t out_data
);
  import krm_pkg::*;

  localparam int unsigned WAW = (WINDOW_BUCKETS > 1) ? $clog2(WINDOW_BUCKETS) : 1;
  localparam int unsigned HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned PW  = AGE_W + 1;

  // pointer and read-issue side
  logic            accept;
  logic [WAW-1:0]  wptr_r, wptr_nxt;
  logic [HAW-1:0]  hptr_r, hptr_nxt;
  logic [PW-1:0]   hptr_ext, age_ext, pos_diff, pos_full;
  logic            age_ok;

  // execute stage
  logic            s1_valid_r;
  op_t             s1_op_r;
  logic            s1_age_ok_r;
  logic [WAW-1:0]  s1_waddr_r;
  logic [HAW-1:0]  s1_haddr_r;
  logic            advance;
  logic            exec;

  logic [RATE_W-1:0] bucket_r, bucket_nxt;
  logic [RATE_W-1:0] sum_r, sum_nxt;
  logic [RATE_W-1:0] peak_r, peak_nxt;
  logic [RATE_W-1:0] hist_val;
  logic [RATE_W-1:0] win_rd, hist_rd;
  logic              win_wr, hist_wr;

  logic            out_valid_r;
  out_t            out_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;
  assign exec     = s1_valid_r && advance;

  assign wptr_nxt = (wptr_r == WAW'(WINDOW_BUCKETS - 1)) ? '0 : wptr_r + 1'b1;
  assign hptr_nxt = (hptr_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : hptr_r + 1'b1;

  // history position a given age back, wrapping round the ring
  assign hptr_ext = PW'(hptr_r);
  assign age_ext  = PW'(in_data.history_age);
  assign age_ok   = age_ext < PW'(HISTORY_DEPTH);
  assign pos_diff = hptr_ext - age_ext;
  assign pos_full = (hptr_ext >= age_ext) ? pos_diff : pos_diff + PW'(HISTORY_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      hptr_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept && in_data.operation == OP_REFRESH) begin
        wptr_r <= wptr_nxt;
      end
      if (accept && in_data.operation == OP_HISTORY) begin
        hptr_r <= hptr_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_data.operation;
      s1_age_ok_r <= age_ok;
      s1_waddr_r  <= wptr_nxt;
      s1_haddr_r  <= hptr_nxt;
    end
  end

  assign win_wr  = exec && s1_op_r == OP_REFRESH;
  assign hist_wr = exec && s1_op_r == OP_HISTORY;

  krm_ring #(
    .DEPTH (WINDOW_BUCKETS),
    .AW    (WAW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (wptr_nxt),
    .wr_en   (win_wr),
    .wr_addr (s1_waddr_r),
    .wr_data (bucket_r),
    .rd_data (win_rd)
  );

  krm_ring #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (HAW)
  ) u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (pos_full[HAW-1:0]),
    .wr_en   (hist_wr),
    .wr_addr (s1_haddr_r),
    .wr_data (peak_r),
    .rd_data (hist_rd)
  );

  always_comb begin
    bucket_nxt = bucket_r;
    sum_nxt    = sum_r;
    peak_nxt   = peak_r;
    hist_val   = '0;
    case (s1_op_r)
      OP_KEYSTROKE: begin
        bucket_nxt = bucket_r + 1'b1;
      end
      OP_REFRESH: begin
        // running sum: drop the outgoing bucket, add the incoming one
        sum_nxt    = sum_r - win_rd + bucket_r;
        peak_nxt   = (peak_r < sum_nxt) ? sum_nxt : peak_r;
        bucket_nxt = '0;
      end
      OP_HISTORY: begin
        peak_nxt = '0;
      end
      OP_READ: begin
        hist_val = s1_age_ok_r ? hist_rd : '0;
      end
      default: begin
        bucket_nxt = bucket_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r    <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        bucket_r <= bucket_nxt;
        sum_r    <= sum_nxt;
        peak_r   <= peak_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_r.current_rate  <= sum_nxt;
      out_r.peak_rate     <= peak_nxt;
      out_r.history_value <= hist_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
